FILE: rtl/core/gdf_pkg.sv
package gdf_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int ADDR_W     = $clog2(MAX_WINDOW);
   localparam int LEN_W      = ADDR_W + 1;

   localparam logic [16:0] METRE_NUM = 17'd111120;
   localparam logic [23:0] METRE_DEN = 24'd10000000;

   localparam int SUM_W     = 32 + ADDR_W + 1;
   localparam int DSUM_W    = 32 + ADDR_W + 1;
   localparam int DIV_NUM_W = 56;
   localparam int DIV_DEN_W = 30;
   localparam int ROOT_W    = 32;

   localparam logic [1:0] REG_MIN_SPEED = 2'd0;
   localparam logic [1:0] REG_WINDOW    = 2'd1;
   localparam logic [1:0] REG_THRESHOLD = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_S1_RD,
      ST_S1_ACC,
      ST_CLAT,
      ST_CLAT_W,
      ST_CLON,
      ST_CLON_W,
      ST_P2_RD,
      ST_P2_DIFF,
      ST_P2_MUL,
      ST_P2_SQ,
      ST_P2_SQW,
      ST_ML,
      ST_MH,
      ST_DIV,
      ST_DIV_W,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/core/gps_dispersion_flight_detect_core.sv
// A clear, or any item after which the ring is not full, goes straight to the result register.
// When the ring is full after the item, the core sums the n fixes, divides for the lat and
// lon centroids, sums the distances with the 32-step root, then scales and divides.
// One item at a time: req_stall is high outside idle, and the next item is accepted only
// once the result is registered; a stalled result register holds it back as well.
// Reset: synchronous, clears control, ring index and full flag and loads register defaults.
module gps_dispersion_flight_detect_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic signed [30:0] req_lat,
   input  logic signed [31:0] req_lon,
   input  logic [8:0]  req_speed_kmh,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_in_flight,
   output logic        rsp_ring_full,
   output logic [15:0] rsp_mean_dispersion_m,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import gdf_pkg::*;

   state_type state_ff, state_in;

   logic [8:0]  min_speed_ff;
   logic [6:0]  window_ff;
   logic [15:0] threshold_ff;
   logic        cfg_wr;

   logic [ADDR_W-1:0] widx_ff, widx_in;
   logic              full_ff, full_in;
   logic [LEN_W-1:0]  n;
   logic [LEN_W-1:0]  widx_eff, widx_inc;
   logic              accept, fix_ok;

   logic [63:0] mem [MAX_WINDOW];
   logic [63:0] rdata_ff;
   logic        mem_we;

   logic [LEN_W-1:0] idx_ff;
   logic             last;
   logic signed [SUM_W-1:0] slat_ff, slon_ff;
   logic signed [31:0] clat_ff, clon_ff;
   logic [31:0] a_ff, b_ff;
   logic [63:0] a2_ff, b2_ff;
   logic [64:0] sq;
   logic signed [32:0] dlat, dlon;
   logic [DSUM_W-1:0] dsum_ff;
   logic [DIV_NUM_W-1:0] prod_ff;
   logic [SUM_W-1:0] mag_lat, mag_lon;
   logic [DIV_NUM_W-1:0] qmag;

   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        sq_start, sq_done;
   logic [ROOT_W-1:0] root;

   logic        rsp_valid_ff;
   logic        in_flight_ff, ring_full_ff;
   logic [15:0] mean_ff, mean_val;
   logic        div_start, rsp_load;

   // configuration
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[3:2])
         REG_MIN_SPEED: prdata = {23'd0, min_speed_ff};
         REG_WINDOW:    prdata = {25'd0, window_ff};
         REG_THRESHOLD: prdata = {16'd0, threshold_ff};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_speed_ff <= 9'd5;
         window_ff    <= 7'd30;
         threshold_ff <= 16'd30;
      end else if (cfg_wr) begin
         if (paddr[3:2] == REG_MIN_SPEED) min_speed_ff <= pwdata[8:0];
         if (paddr[3:2] == REG_WINDOW)    window_ff    <= pwdata[6:0];
         if (paddr[3:2] == REG_THRESHOLD) threshold_ff <= pwdata[15:0];
      end
   end

   always_comb begin
      if (window_ff == '0)                     n = LEN_W'(1);
      else if (window_ff > 7'(MAX_WINDOW))     n = LEN_W'(MAX_WINDOW);
      else                                     n = LEN_W'(window_ff);
   end

   // ring bookkeeping
   assign accept   = req_valid && !req_stall;
   assign fix_ok   = !req_command && (req_speed_kmh >= min_speed_ff);
   assign widx_eff = ({1'b0, widx_ff} >= n) ? '0 : {1'b0, widx_ff};
   assign widx_inc = widx_eff + 1'b1;
   assign mem_we   = accept && fix_ok;

   always_comb begin
      widx_in = widx_ff;
      full_in = full_ff;
      if (cfg_wr && paddr[3:2] == REG_WINDOW) begin
         widx_in = '0;
         full_in = 1'b0;
      end else if (accept) begin
         if (req_command) begin
            widx_in = '0;
            full_in = 1'b0;
         end else if (fix_ok) begin
            if (widx_inc >= n) begin
               widx_in = '0;
               full_in = 1'b1;
            end else begin
               widx_in = widx_inc[ADDR_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         widx_ff <= widx_in;
         full_ff <= full_in;
      end
   end

   // fix memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[widx_eff[ADDR_W-1:0]] <= {32'(req_lat), req_lon};
      rdata_ff <= mem[idx_ff[ADDR_W-1:0]];
   end

   // sequencer
   assign last = (idx_ff + 1'b1) == n;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept) state_in = full_in ? ST_S1_RD : ST_OUT;
         ST_S1_RD:   state_in = ST_S1_ACC;
         ST_S1_ACC:  state_in = last ? ST_CLAT : ST_S1_RD;
         ST_CLAT:    state_in = ST_CLAT_W;
         ST_CLAT_W:  if (div_rsp.done) state_in = ST_CLON;
         ST_CLON:    state_in = ST_CLON_W;
         ST_CLON_W:  if (div_rsp.done) state_in = ST_P2_RD;
         ST_P2_RD:   state_in = ST_P2_DIFF;
         ST_P2_DIFF: state_in = ST_P2_MUL;
         ST_P2_MUL:  state_in = ST_P2_SQ;
         ST_P2_SQ:   state_in = ST_P2_SQW;
         ST_P2_SQW:  if (sq_done) state_in = last ? ST_ML : ST_P2_RD;
         ST_ML:      state_in = ST_MH;
         ST_MH:      state_in = ST_DIV;
         ST_DIV:     state_in = ST_DIV_W;
         ST_DIV_W:   if (div_rsp.done) state_in = ST_OUT;
         ST_OUT:     if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = state_ff != ST_IDLE;
      div_start = (state_ff == ST_CLAT) || (state_ff == ST_CLON) || (state_ff == ST_DIV);
      sq_start  = state_ff == ST_P2_SQ;
      rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // datapath
   assign mag_lat = slat_ff[SUM_W-1] ? SUM_W'(-slat_ff) : SUM_W'(slat_ff);
   assign mag_lon = slon_ff[SUM_W-1] ? SUM_W'(-slon_ff) : SUM_W'(slon_ff);
   assign qmag    = div_rsp.quotient;

   always_comb begin
      div_req.start = div_start;
      unique case (state_ff)
         ST_CLAT: div_req.dividend = DIV_NUM_W'(mag_lat);
         ST_CLON: div_req.dividend = DIV_NUM_W'(mag_lon);
         default: div_req.dividend = prod_ff;
      endcase
      if (state_ff == ST_DIV || state_ff == ST_DIV_W)
         div_req.divisor = DIV_DEN_W'(n * METRE_DEN);
      else
         div_req.divisor = DIV_DEN_W'(n);
   end

   assign dlat = 33'(signed'(rdata_ff[63:32])) - 33'(clat_ff);
   assign dlon = 33'(signed'(rdata_ff[31:0])) - 33'(clon_ff);
   assign sq   = {1'b0, a2_ff} + {1'b0, b2_ff};

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            idx_ff  <= '0;
            slat_ff <= '0;
            slon_ff <= '0;
            dsum_ff <= '0;
         end
         ST_S1_ACC: begin
            slat_ff <= slat_ff + SUM_W'(signed'(rdata_ff[63:32]));
            slon_ff <= slon_ff + SUM_W'(signed'(rdata_ff[31:0]));
            idx_ff  <= last ? '0 : idx_ff + 1'b1;
         end
         ST_CLAT_W: if (div_rsp.done)
            clat_ff <= slat_ff[SUM_W-1] ? -32'(qmag) : 32'(qmag);
         ST_CLON_W: if (div_rsp.done)
            clon_ff <= slon_ff[SUM_W-1] ? -32'(qmag) : 32'(qmag);
         ST_P2_DIFF: begin
            a_ff <= dlat[32] ? 32'(-dlat) : dlat[31:0];
            b_ff <= dlon[32] ? 32'(-dlon) : dlon[31:0];
         end
         ST_P2_MUL: begin
            a2_ff <= 64'(a_ff) * 64'(a_ff);
            b2_ff <= 64'(b_ff) * 64'(b_ff);
         end
         ST_P2_SQW: if (sq_done) begin
            dsum_ff <= dsum_ff + DSUM_W'(root);
            idx_ff  <= idx_ff + 1'b1;
         end
         ST_ML: prod_ff <= DIV_NUM_W'(dsum_ff[19:0] * METRE_NUM);
         ST_MH: prod_ff <= prod_ff
                           + (DIV_NUM_W'(dsum_ff[DSUM_W-1:20] * METRE_NUM) << 20);
         default: ;
      endcase
   end

   gdf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   gdf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq[63:0]),
      .done     (sq_done),
      .root     (root)
   );

   // result register
   assign mean_val = !full_ff ? 16'd0 :
                     (qmag > DIV_NUM_W'(16'hFFFF)) ? 16'hFFFF : qmag[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         mean_ff      <= mean_val;
         ring_full_ff <= full_ff;
         in_flight_ff <= full_ff && (mean_val >= threshold_ff);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_in_flight         = in_flight_ff;
   assign rsp_ring_full         = ring_full_ff;
   assign rsp_mean_dispersion_m = mean_ff;

   a_widx_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, widx_ff} < n)
      else $error("ring index beyond window");
   a_pass2_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_P2_RD |-> full_ff)
      else $error("distance pass on a ring that is not full");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("item accepted without leaving idle");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

endmodule

FILE: rtl/core/gdf_div.sv
module gdf_div (
   input  logic               clock,
   input  logic               reset,
   input  gdf_pkg::div_req_type req,
   output gdf_pkg::div_rsp_type rsp
);
   import gdf_pkg::*;

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [$clog2(DIV_NUM_W)-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DIV_DEN_W:0] trial;
   logic               fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_NUM_W-1]};
      fits   = trial >= {1'b0, req.divisor};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         cnt_in  = ($clog2(DIV_NUM_W))'(DIV_NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_DEN_W'(trial - {1'b0, req.divisor}) : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

FILE: rtl/core/gdf_sqrt.sv
module gdf_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [gdf_pkg::ROOT_W-1:0] root
);
   import gdf_pkg::*;

   logic [63:0] x_ff, x_in, r_ff, r_in, bit_ff, bit_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [63:0] rb;

   always_comb begin
      rb      = r_ff + bit_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         r_in    = '0;
         bit_in  = 64'd1 << 62;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= rb) begin
            x_in = x_ff - rb;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = r_ff[ROOT_W-1:0];

endmodule

FILE: verif/tb_gps_dispersion_flight_detect_core.sv
module tb_gps_dispersion_flight_detect_core;
   timeunit 1ns;
   timeprecision 1ps;
   import gdf_pkg::*;

   localparam int WDOG_LIMIT = 40000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = 1'b0;
   logic signed [30:0] req_lat = '0;
   logic signed [31:0] req_lon = '0;
   logic [8:0]  req_speed_kmh = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_in_flight;
   logic        rsp_ring_full;
   logic [15:0] rsp_mean_dispersion_m;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   gps_dispersion_flight_detect_core DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   typedef struct packed {
      logic        in_flight;
      logic        ring_full;
      logic [15:0] mean_m;
   } dispersion_type;

   typedef struct {
      bit          is_cfg;
      logic [1:0]  reg_idx;
      logic [31:0] reg_val;
      logic        command;
      logic [30:0] lat;
      logic [31:0] lon;
      logic [8:0]  speed;
      bit          typed;
      dispersion_type result;
   } stim_row_type;

   // predictor state
   logic [8:0]  cur_min_speed;
   logic [6:0]  cur_window;
   logic [15:0] cur_threshold;
   longint      ring_lat [MAX_WINDOW];
   longint      ring_lon [MAX_WINDOW];
   int unsigned ring_wr;
   bit          ring_is_full;

   dispersion_type expected_q [$];
   int          mismatches = 0;
   int          results_seen = 0;
   int          flights_seen = 0;
   int          items_sent = 0;
   bit          quiet = 1'b0;
   int          wdog = 0;

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic int unsigned ring_len();
      if (cur_window == 0) return 1;
      if (cur_window > MAX_WINDOW) return MAX_WINDOW;
      return cur_window;
   endfunction

   function automatic longint unsigned mean_metres(int unsigned n);
      longint          slat, slon, clat, clon, dlat, dlon;
      longint unsigned a, b, a2, b2, s, dsum, m;
      slat = 0;
      slon = 0;
      dsum = 0;
      for (int i = 0; i < n; i++) begin
         slat += ring_lat[i];
         slon += ring_lon[i];
      end
      clat = slat / longint'(n);
      clon = slon / longint'(n);
      for (int i = 0; i < n; i++) begin
         dlat = ring_lat[i] - clat;
         dlon = ring_lon[i] - clon;
         a = dlat < 0 ? -dlat : dlat;
         b = dlon < 0 ? -dlon : dlon;
         a2 = a * a;
         b2 = b * b;
         s = (a2 > 64'hFFFF_FFFF_FFFF_FFFF - b2) ? 64'hFFFF_FFFF_FFFF_FFFF : a2 + b2;
         dsum += int_sqrt(s);
      end
      m = (dsum * 64'd111120) / (64'd10000000 * n);
      return m > 65535 ? 65535 : m;
   endfunction

   function automatic dispersion_type predict_dispersion(logic cmd, logic signed [30:0] lat,
                                                          logic signed [31:0] lon,
                                                          logic [8:0] spd);
      int unsigned     n;
      longint unsigned m;
      dispersion_type  r;
      n = ring_len();
      m = 0;
      if (cmd) begin
         ring_wr = 0;
         ring_is_full = 0;
      end else if (spd >= cur_min_speed) begin
         if (ring_wr >= n) ring_wr = 0;
         ring_lat[ring_wr] = lat;
         ring_lon[ring_wr] = lon;
         ring_wr++;
         if (ring_wr >= n) begin
            ring_wr = 0;
            ring_is_full = 1;
         end
      end
      if (ring_is_full) m = mean_metres(n);
      r.in_flight = ring_is_full && (m >= cur_threshold);
      r.ring_full = ring_is_full;
      r.mean_m = m[15:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      dispersion_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_in_flight) flights_seen++;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected item, in_flight", rsp_in_flight, -1);
         end else begin
            want = expected_q.pop_front();
            if (rsp_in_flight !== want.in_flight)
               report_mismatch("in_flight", rsp_in_flight, want.in_flight);
            if (rsp_ring_full !== want.ring_full)
               report_mismatch("ring_full", rsp_ring_full, want.ring_full);
            if (rsp_mean_dispersion_m !== want.mean_m)
               report_mismatch("mean_dispersion_m", rsp_mean_dispersion_m, want.mean_m);
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 17);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         wdog <= 0;
      end else begin
         wdog <= wdog + 1;
         if (wdog >= WDOG_LIMIT) begin
            $display("watchdog expired with %0d items outstanding", expected_q.size());
            $display("tb_gps_dispersion_flight_detect_core failed");
            $finish;
         end
      end
   end

   task automatic send_item(logic cmd, logic [30:0] lat, logic [31:0] lon, logic [8:0] spd,
                            bit typed, dispersion_type typed_res);
      dispersion_type p;
      if (!quiet && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      p = predict_dispersion(cmd, lat, lon, spd);
      expected_q.push_back(typed ? typed_res : p);
      items_sent++;
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_lat       <= lat;
      req_lon       <= lon;
      req_speed_kmh <= spd;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_MIN_SPEED: cur_min_speed = val[8:0];
         REG_WINDOW: begin
            cur_window = val[6:0];
            ring_wr = 0;
            ring_is_full = 0;
         end
         REG_THRESHOLD: cur_threshold = val[15:0];
         default: ;
      endcase
   endtask

   localparam logic [30:0] LAT_MAX = 31'h3FFF_FFFF;
   localparam logic [30:0] LAT_MIN = 31'h4000_0000;
   localparam logic [31:0] LON_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] LON_MIN = 32'h8000_0000;
   localparam dispersion_type NONE = '{1'b0, 1'b0, 16'd0};
   localparam dispersion_type SINGLE_FLY = '{1'b1, 1'b1, 16'd0};

   stim_row_type directed [] = '{
      '{0, REG_MIN_SPEED, 0, 1'b0, 31'd0, 32'd0, 9'd100, 1, NONE},
      '{0, REG_MIN_SPEED, 0, 1'b1, LAT_MAX, LON_MAX, 9'd511, 1, NONE},
      '{0, REG_MIN_SPEED, 0, 1'b0, 31'd5, 32'd5, 9'd4, 1, NONE},
      '{1, REG_WINDOW, 0, 1'b0, 31'd0, 32'd0, 9'd0, 0, NONE},
      '{1, REG_THRESHOLD, 0, 1'b0, 31'd0, 32'd0, 9'd0, 0, NONE},
      '{0, REG_MIN_SPEED, 0, 1'b0, LAT_MAX, LON_MAX, 9'd5, 1, SINGLE_FLY},
      '{0, REG_MIN_SPEED, 0, 1'b0, LAT_MIN, LON_MIN, 9'd511, 1, SINGLE_FLY},
      '{0, REG_MIN_SPEED, 0, 1'b0, 31'd0, 32'd0, 9'd0, 1, SINGLE_FLY},
      '{0, REG_MIN_SPEED, 0, 1'b1, 31'd0, 32'd0, 9'd0, 1, NONE},
      '{1, REG_WINDOW, 2, 1'b0, 31'd0, 32'd0, 9'd0, 0, NONE},
      '{1, REG_THRESHOLD, 65535, 1'b0, 31'd0, 32'd0, 9'd0, 0, NONE},
      '{0, REG_MIN_SPEED, 0, 1'b0, LAT_MAX, LON_MAX, 9'd200, 0, NONE},
      '{0, REG_MIN_SPEED, 0, 1'b0, LAT_MIN, LON_MIN, 9'd200, 0, NONE},
      '{0, REG_MIN_SPEED, 0, 1'b0, 31'd0, 32'd0, 9'd200, 0, NONE},
      '{0, REG_MIN_SPEED, 0, 1'b0, 31'd1000, 32'hFFFF_F000, 9'd200, 0, NONE},
      '{1, REG_MIN_SPEED, 511, 1'b0, 31'd0, 32'd0, 9'd0, 0, NONE},
      '{0, REG_MIN_SPEED, 0, 1'b0, 31'd77, 32'd99, 9'd510, 0, NONE},
      '{0, REG_MIN_SPEED, 0, 1'b0, 31'd8000, 32'd12000, 9'd511, 0, NONE},
      '{0, REG_MIN_SPEED, 0, 1'b0, 31'h2AAA_AAAA, 32'h5555_5555, 9'd511, 0, NONE},
      '{1, REG_WINDOW, 127, 1'b0, 31'd0, 32'd0, 9'd0, 0, NONE}
   };

   // min speed, window, threshold, items
   int phases [6][4] = '{
      '{0, 64, 0, 70}, '{20, 3, 50, 60}, '{5, 8, 200, 60},
      '{511, 1, 65535, 20}, '{0, 5, 10, 40}, '{100, 2, 1000, 40}
   };

   initial begin
      logic [30:0] base_lat, lat;
      logic [31:0] base_lon, lon;
      logic [8:0]  spd;
      int          spread, n;
      cur_min_speed = 9'd5;
      cur_window    = 7'd30;
      cur_threshold = 16'd30;
      ring_wr       = 0;
      ring_is_full  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_cfg)
            csr_write(directed[i].reg_idx, directed[i].reg_val);
         else
            send_item(directed[i].command, directed[i].lat, directed[i].lon,
                      directed[i].speed, directed[i].typed, directed[i].result);
      end

      for (int ph = 0; ph < 6; ph++) begin
         csr_write(REG_MIN_SPEED, phases[ph][0]);
         csr_write(REG_WINDOW, phases[ph][1]);
         csr_write(REG_THRESHOLD, phases[ph][2]);
         quiet = (ph == 2);
         n = phases[ph][1];
         base_lat = $signed(31'($urandom_range(0, 1800000000))) - 31'sd900000000;
         base_lon = $urandom_range(0, 3600000000) - 32'd1800000000;
         for (int k = 0; k < phases[ph][3]; k++) begin
            spread = ($urandom_range(3) == 0) ? 2000000 : 3000;
            lat = 31'(base_lat + $signed(31'($urandom_range(0, 2 * spread))) - spread);
            lon = 32'(base_lon + $urandom_range(0, 2 * spread) - spread);
            spd = ($urandom_range(9) < 8) ? 9'($urandom_range(phases[ph][0], 511))
                                           : 9'($urandom_range(0, 511));
            if ($urandom_range(9) == 0) begin
               lat = 31'($urandom);
               lon = $urandom;
            end
            send_item($urandom_range(0, 6 * n) == 0, lat, lon, spd, 0, NONE);
         end
      end

      req_valid <= 1'b0;
      quiet = 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("%0d items sent, %0d results checked, %0d with in_flight set",
               items_sent, results_seen, flights_seen);
      $display("window lengths 0..127, min speed and threshold extremes, clears, slow fixes");
      if (mismatches == 0 && expected_q.size() == 0)
         $display("tb_gps_dispersion_flight_detect_core passed");
      else
         $display("tb_gps_dispersion_flight_detect_core failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/gdf_pkg.sv
rtl/core/gdf_div.sv
rtl/core/gdf_sqrt.sv
rtl/core/gps_dispersion_flight_detect_core.sv
verif/tb_gps_dispersion_flight_detect_core.sv
